FILE: src/trimmed_mean_sample_filter_macros.svh
// Assertion helpers for the trimmed-mean filter.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef TRIMMED_MEAN_SAMPLE_FILTER_MACROS_SVH
`define TRIMMED_MEAN_SAMPLE_FILTER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TMSF_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("trimmed mean filter: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define TMSF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("trimmed mean filter: next-cycle check failed");

`endif

FILE: src/tmsf_pkg.sv
`default_nettype none

package tmsf_pkg;

  // Width of one converter code and of one result.
  localparam int unsigned CODE_W = 24;

  // Default number of samples in one batch.
  localparam int unsigned DEF_BATCH_SIZE = 8;

  // Status of the divide pipeline as seen by the top level.
  typedef struct packed {
    logic busy;
    logic res_valid;
  } div_stat_t;

endpackage

`default_nettype wire

FILE: src/tmsf_accum.sv
`default_nettype none

module tmsf_accum #(
  parameter int unsigned BATCH_SIZE = tmsf_pkg::DEF_BATCH_SIZE,
  localparam int unsigned SW = tmsf_pkg::CODE_W + $clog2(BATCH_SIZE),
  localparam int unsigned PW = $clog2(BATCH_SIZE)
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         adv,
  input  wire logic                         take,
  input  wire logic [tmsf_pkg::CODE_W-1:0]  code,
  output logic                              batch_valid,
  output logic signed [SW-1:0]              batch_sum,
  output logic signed [tmsf_pkg::CODE_W-1:0] batch_max,
  output logic signed [tmsf_pkg::CODE_W-1:0] batch_min,
  output logic [PW-1:0]                     pos
);
  import tmsf_pkg::*;

  logic [PW-1:0]              pos_r;
  logic signed [SW-1:0]       sum_r;
  logic signed [CODE_W-1:0]   max_r;
  logic signed [CODE_W-1:0]   min_r;
  logic                       bvalid_r;
  logic signed [SW-1:0]       bsum_r;
  logic signed [CODE_W-1:0]   bmax_r;
  logic signed [CODE_W-1:0]   bmin_r;

  logic signed [CODE_W-1:0]   sample;
  logic signed [SW-1:0]       sample_ext;
  logic signed [SW-1:0]       sum_nxt;
  logic signed [CODE_W-1:0]   max_nxt;
  logic signed [CODE_W-1:0]   min_nxt;
  logic                       first;
  logic                       last;

  // The raw code is already two's complement; widen it for the sum.
  assign sample     = signed'(code);
  assign sample_ext = {{(SW - CODE_W){code[CODE_W-1]}}, code};
  assign first      = (pos_r == '0);
  assign last       = (pos_r == PW'(BATCH_SIZE - 1));

  // The first sample of a batch seeds the sum and both extremes.
  always_comb begin
    sum_nxt = first ? sample_ext : sum_r + sample_ext;
    max_nxt = (first || (sample > max_r)) ? sample : max_r;
    min_nxt = (first || (sample < min_r)) ? sample : min_r;
  end

  // Control state: position within the batch and the batch-complete flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      bvalid_r <= 1'b0;
    end else begin
      if (adv) begin
        bvalid_r <= take && last;
      end
      if (take) begin
        pos_r <= last ? '0 : pos_r + 1'b1;
      end
    end
  end

  // Running totals, and the totals of a finished batch handed on.
  always_ff @(posedge clk) begin
    if (take) begin
      sum_r <= sum_nxt;
      max_r <= max_nxt;
      min_r <= min_nxt;
    end
    if (take && last) begin
      bsum_r <= sum_nxt;
      bmax_r <= max_nxt;
      bmin_r <= min_nxt;
    end
  end

  assign batch_valid = bvalid_r;
  assign batch_sum   = bsum_r;
  assign batch_max   = bmax_r;
  assign batch_min   = bmin_r;
  assign pos         = pos_r;

endmodule

`default_nettype wire

FILE: src/tmsf_divide.sv
`default_nettype none

module tmsf_divide #(
  parameter int unsigned BATCH_SIZE = tmsf_pkg::DEF_BATCH_SIZE,
  localparam int unsigned SW = tmsf_pkg::CODE_W + $clog2(BATCH_SIZE)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          adv,
  input  wire logic                          batch_valid,
  input  wire logic signed [SW-1:0]          batch_sum,
  input  wire logic signed [tmsf_pkg::CODE_W-1:0] batch_max,
  input  wire logic signed [tmsf_pkg::CODE_W-1:0] batch_min,
  output tmsf_pkg::div_stat_t                stat,
  output logic [tmsf_pkg::CODE_W-1:0]        quotient
);
  import tmsf_pkg::*;

  // Divisor and an exact reciprocal for magnitudes below 2**AW.
  localparam int unsigned DIV = BATCH_SIZE - 2;
  localparam int unsigned AW  = SW - 1;
  localparam int unsigned LD  = $clog2(DIV);
  localparam int unsigned K   = AW + LD;
  localparam int unsigned MW  = AW + 2;
  localparam int unsigned PRW = AW + MW;
  localparam longint unsigned RECIP =
    ((64'd1 << K) + 64'(DIV) - 64'd1) / 64'(DIV);
  localparam logic [MW-1:0] RECIP_M = RECIP[MW-1:0];

  logic                   v1_r, v2_r, v3_r;
  logic signed [SW-1:0]   trim_r;
  logic [AW-1:0]          mag_r;
  logic                   neg2_r;
  logic [PRW-1:0]         prod_r;
  logic                   neg3_r;

  logic signed [SW+1:0]   trim_wide;
  logic [SW-1:0]          mag_full;
  logic [PRW-1:0]         prod_shift;
  logic [CODE_W-1:0]      q_mag;

  // Remove one largest and one smallest sample; the result fits SW bits.
  assign trim_wide = (SW+2)'(batch_sum) - (SW+2)'(batch_max) - (SW+2)'(batch_min);

  // Magnitude of the trimmed sum, so the division truncates toward zero.
  assign mag_full = trim_r[SW-1] ? SW'(-trim_r) : SW'(trim_r);

  // Quotient magnitude from the scaled product, then the sign restored.
  assign prod_shift = prod_r >> K;
  assign q_mag      = prod_shift[CODE_W-1:0];
  assign quotient   = neg3_r ? CODE_W'(-q_mag) : q_mag;

  // Stage valid flags advance together with the rest of the pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= batch_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Data stages: trim, take magnitude, multiply by the reciprocal.
  always_ff @(posedge clk) begin
    if (adv) begin
      trim_r <= trim_wide[SW-1:0];
      mag_r  <= mag_full[AW-1:0];
      neg2_r <= trim_r[SW-1];
      prod_r <= PRW'(mag_r) * PRW'(RECIP_M);
      neg3_r <= neg2_r;
    end
  end

  assign stat.busy      = v1_r || v2_r || v3_r;
  assign stat.res_valid = v3_r;

endmodule

`default_nettype wire

FILE: src/trimmed_mean_sample_filter.sv
// Trimmed-mean sample filter.
// Input channel: in_valid/in_ready with in_sample_code, a 24-bit two's-complement
// converter code. Output channel: out_valid/out_ready with out_filtered_value, the
// signed mean of a batch of BATCH_SIZE samples after removing one largest and one
// smallest sample, truncated toward zero.
// Only the last item of a batch produces a result; the others produce none.
// Throughput: one item per cycle while the receiver keeps up.
// After the last item of a batch is accepted, its result passes these registers in
// order before out_valid rises: the batch totals, registered at the accepting edge,
// then trim, magnitude and a constant reciprocal multiply, each registered, then
// the output register.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// in_ready falls in the same cycle; nothing is dropped or repeated.
// Reset clears the batch position and every valid flag, so the next accepted
// item starts a fresh batch. The reset is synchronous and active low.
`default_nettype none

`include "trimmed_mean_sample_filter_macros.svh"

module trimmed_mean_sample_filter #(
  parameter int unsigned BATCH_SIZE = tmsf_pkg::DEF_BATCH_SIZE
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [tmsf_pkg::CODE_W-1:0]        in_sample_code,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [tmsf_pkg::CODE_W-1:0]      out_filtered_value
);
  import tmsf_pkg::*;

  localparam int unsigned SW = CODE_W + $clog2(BATCH_SIZE);
  localparam int unsigned PW = $clog2(BATCH_SIZE);

  logic                      adv;
  logic                      take;
  logic                      batch_valid;
  logic signed [SW-1:0]      batch_sum;
  logic signed [CODE_W-1:0]  batch_max;
  logic signed [CODE_W-1:0]  batch_min;
  logic [PW-1:0]             pos;
  div_stat_t                 div_stat;
  logic [CODE_W-1:0]         quotient;
  logic                      out_valid_r;
  logic signed [CODE_W-1:0]  out_value_r;

  // The pipeline moves whenever the output register is free or being emptied.
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;
  assign take     = in_valid && adv;

  tmsf_accum #(
    .BATCH_SIZE (BATCH_SIZE)
  ) u_accum (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .take        (take),
    .code        (in_sample_code),
    .batch_valid (batch_valid),
    .batch_sum   (batch_sum),
    .batch_max   (batch_max),
    .batch_min   (batch_min),
    .pos         (pos)
  );

  tmsf_divide #(
    .BATCH_SIZE (BATCH_SIZE)
  ) u_divide (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .batch_valid (batch_valid),
    .batch_sum   (batch_sum),
    .batch_max   (batch_max),
    .batch_min   (batch_min),
    .stat        (div_stat),
    .quotient    (quotient)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= div_stat.res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && div_stat.res_valid) begin
      out_value_r <= signed'(quotient);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_filtered_value = out_value_r;

  // The last item of a batch returns the position to the start.
  `TMSF_ASSERT_NEXT(a_batch_wrap, take && (pos == PW'(BATCH_SIZE - 1)), pos == '0)
  // A stalled receiver freezes the divide pipeline.
  `TMSF_ASSERT_NEXT(a_stall_hold, !adv, $stable(div_stat))
  // A new result only ever comes from the last divide stage.
  `TMSF_ASSERT_SAME(a_result_src, $rose(out_valid_r), $past(div_stat.res_valid))

endmodule

`default_nettype wire
